FILE: hdl/sm_exec_pkg.sv
// ============================================================================
// Stack machine execute step package
// Shared sizes, opcodes, status codes and controller/datapath command types.
// ============================================================================
`default_nettype none

package sm_exec_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_WORDS  = 256;
  localparam int CODE_WORDS  = 1024;

  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DA_W  = $clog2(DATA_WORDS);
  localparam int PC_W  = $clog2(CODE_WORDS + 1);

  localparam logic [31:0] EMPTY_VALUE = 32'h7fff_ffff;

  // Opcodes.
  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_IN   = 8'd1;
  localparam logic [7:0] OP_OUT  = 8'd2;
  localparam logic [7:0] OP_ADD  = 8'd3;
  localparam logic [7:0] OP_SUB  = 8'd4;
  localparam logic [7:0] OP_MUL  = 8'd5;
  localparam logic [7:0] OP_DIV  = 8'd6;
  localparam logic [7:0] OP_DUP  = 8'd7;
  localparam logic [7:0] OP_LD   = 8'd8;
  localparam logic [7:0] OP_ST   = 8'd9;
  localparam logic [7:0] OP_LDC  = 8'd10;
  localparam logic [7:0] OP_JLT  = 8'd11;
  localparam logic [7:0] OP_JLE  = 8'd12;
  localparam logic [7:0] OP_JGT  = 8'd13;
  localparam logic [7:0] OP_JGE  = 8'd14;
  localparam logic [7:0] OP_JEQ  = 8'd15;
  localparam logic [7:0] OP_JNE  = 8'd16;
  localparam logic [7:0] OP_JMP  = 8'd17;

  // Status codes.
  localparam logic [2:0] ST_OKAY  = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_DIV0  = 3'd2;
  localparam logic [2:0] ST_DADDR = 3'd3;
  localparam logic [2:0] ST_CADDR = 3'd4;
  localparam logic [2:0] ST_BADOP = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture opcode and operands
    logic pop_a;       // pop into operand a (read issued)
    logic pop_b;       // pop into operand b (read issued)
    logic cap_a;       // register stack read data into a
    logic cap_b;       // register stack read data into b
    logic peek_a;      // read top without popping
    logic mem_rd;      // read data memory at a
    logic div_start;   // start the divider
    logic finish;      // commit result and present it
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/sm_exec_div.sv
// ============================================================================
// Stack machine divider
// Signed 32-bit radix-2 restoring divider, truncating toward zero.
// ============================================================================
`default_nettype none

module sm_exec_div
  import sm_exec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic [31:0]      quo
);

  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem, q[31]} - {1'b0, d};
  assign quo   = neg ? (32'd0 - q) : q;

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      rem  <= '0;
      q    <= num[31] ? (32'd0 - num) : num;
      d    <= den[31] ? (32'd0 - den) : den;
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], q[31]};
        q   <= {q[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sm_exec_dp.sv
// ============================================================================
// Stack machine datapath
// Operand stack and data memories, operand registers, ALU, pc and result.
// ============================================================================
`default_nettype none

module sm_exec_dp
  import sm_exec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [7:0]  opcode,
  input  wire logic [31:0] immediate,
  input  wire logic [31:0] in_value,
  output logic [2:0]       status,
  output logic [10:0]      next_pc,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             stack_fault
);

  logic [31:0]      stack_mem [STACK_DEPTH];
  logic [31:0]      data_mem  [DATA_WORDS];
  logic [DATA_WORDS-1:0] dvalid;
  logic [31:0]      stack_rd;
  logic [31:0]      data_rd;
  logic             data_rd_ok;
  logic [CNT_W-1:0] cnt;
  logic [PC_W-1:0]  pc;
  logic             stopped;
  logic [2:0]       stop_code;
  logic [7:0]       op;
  logic [31:0]      imm;
  logic [31:0]      inv;
  logic [31:0]      a;
  logic [31:0]      b;
  logic             fault;
  logic             a_empty;
  logic             b_empty;
  logic [31:0]      div_q;
  logic             div_busy;
  logic [63:0]      prod;

  logic             push_en;
  logic [31:0]      push_val;
  logic [2:0]       st_next;
  logic [PC_W-1:0]  pc_next;
  logic             take;
  logic             addr_ok;
  logic [31:0]      maddr;
  logic [PC_W-1:0]  jt;
  logic             running;
  logic             fault_next;

  // A store pops the value first and the address second; a load pops the address.
  assign maddr        = (op == OP_ST) ? b : a;
  assign sts.div_busy = div_busy;
  assign running      = !stopped && (pc < PC_W'(CODE_WORDS));
  assign addr_ok      = !maddr[31] && (maddr < 32'(DATA_WORDS));
  assign jt = (imm[31] || imm >= 32'(CODE_WORDS)) ? PC_W'(CODE_WORDS) : PC_W'(imm);

  sm_exec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (b),
    .den   (a),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // Stack memory read and push write; the read address is the current top.
  always_ff @(posedge clk) begin
    if (cmd.pop_a || cmd.pop_b || cmd.peek_a) begin
      stack_rd <= stack_mem[SP_W'(cnt - CNT_W'(1))];
    end
    if (cmd.finish && push_en && running && cnt < CNT_W'(STACK_DEPTH)) begin
      stack_mem[cnt[SP_W-1:0]] <= push_val;
    end
  end

  // Data memory; a valid bit per word stands in for the cleared reset state.
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      data_rd    <= data_mem[a[DA_W-1:0]];
      data_rd_ok <= dvalid[a[DA_W-1:0]];
    end
    if (cmd.finish && running && op == OP_ST && addr_ok) begin
      data_mem[maddr[DA_W-1:0]] <= a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
    end else if (cmd.finish && running && op == OP_ST && addr_ok) begin
      dvalid[maddr[DA_W-1:0]] <= 1'b1;
    end
  end

  assign prod = 64'(a) * 64'(b);

  // Branch condition on the popped value.
  always_comb begin
    unique case (op)
      OP_JLT:  take = a[31];
      OP_JLE:  take = a[31] || a == 32'd0;
      OP_JGT:  take = !a[31] && a != 32'd0;
      OP_JGE:  take = !a[31];
      OP_JEQ:  take = a == 32'd0;
      OP_JNE:  take = a != 32'd0;
      default: take = 1'b0;
    endcase
  end

  // Result of the instruction, evaluated once operands are in place.
  always_comb begin
    push_en  = 1'b0;
    push_val = '0;
    st_next  = ST_OKAY;
    pc_next  = pc + PC_W'(1);
    unique case (op)
      OP_HALT: st_next = ST_HALT;
      OP_IN:   begin push_en = 1'b1; push_val = inv; end
      OP_OUT:  ;
      OP_ADD:  begin push_en = 1'b1; push_val = b + a; end
      OP_SUB:  begin push_en = 1'b1; push_val = b - a; end
      OP_MUL:  begin push_en = 1'b1; push_val = prod[31:0]; end
      OP_DIV: begin
        if (a == 32'd0) begin
          st_next = ST_DIV0;
        end else begin
          push_en = 1'b1; push_val = div_q;
        end
      end
      OP_DUP:  begin push_en = 1'b1; push_val = a; end
      OP_LD: begin
        if (addr_ok) begin
          push_en = 1'b1; push_val = data_rd_ok ? data_rd : 32'd0;
        end else begin
          st_next = ST_DADDR;
        end
      end
      OP_ST:   if (!addr_ok) st_next = ST_DADDR;
      OP_LDC:  begin push_en = 1'b1; push_val = imm; end
      OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE: if (take) pc_next = jt;
      OP_JMP:  pc_next = jt;
      default: st_next = ST_BADOP;
    endcase
  end

  assign fault_next = fault || (push_en && cnt >= CNT_W'(STACK_DEPTH));

  // Operand capture, pops, and commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      stop_code <= ST_OKAY;
      out_valid <= 1'b0;
      stack_fault <= 1'b0;
      fault     <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        op    <= opcode;
        imm   <= immediate;
        inv   <= in_value;
        fault <= 1'b0;
        a_empty <= 1'b0;
        b_empty <= 1'b0;
      end
      if (cmd.pop_a || cmd.peek_a) begin
        a_empty <= cnt == '0;
        if (cnt == '0) fault <= 1'b1;
        else if (cmd.pop_a) cnt <= cnt - CNT_W'(1);
      end
      if (cmd.pop_b) begin
        b_empty <= cnt == '0;
        if (cnt == '0) fault <= 1'b1;
        else cnt <= cnt - CNT_W'(1);
      end
      if (cmd.cap_a) a <= a_empty ? EMPTY_VALUE : stack_rd;
      if (cmd.cap_b) b <= b_empty ? EMPTY_VALUE : stack_rd;
      if (cmd.finish) begin
        out_valid   <= 1'b0;
        out_value   <= '0;
        stack_fault <= 1'b0;
        next_pc     <= 11'(pc);
        if (stopped) begin
          status <= stop_code;
        end else if (!running) begin
          status    <= ST_CADDR;
          stopped   <= 1'b1;
          stop_code <= ST_CADDR;
        end else begin
          status      <= st_next;
          next_pc     <= 11'(pc_next);
          pc          <= pc_next;
          stack_fault <= fault_next;
          if (op == OP_OUT) begin
            out_valid <= 1'b1;
            out_value <= a;
          end
          if (push_en && cnt < CNT_W'(STACK_DEPTH)) cnt <= cnt + CNT_W'(1);
          if (st_next != ST_OKAY) begin
            stopped   <= 1'b1;
            stop_code <= st_next;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sm_exec_ctrl.sv
// ============================================================================
// Stack machine controller
// Sequences pops, memory reads and the divider for one instruction.
// ============================================================================
`default_nettype none

module sm_exec_ctrl
  import sm_exec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] opcode,
  input  wire logic       out_busy,
  input  wire dp_sts_t    sts,
  output dp_cmd_t         cmd,
  output logic            idle
);

  typedef enum logic [3:0] {
    S_IDLE, S_POPA, S_CAPA, S_POPB, S_CAPB, S_MEM, S_MEMW, S_DIVS, S_DIVW, S_DONE
  } state_t;

  state_t     state;
  logic [7:0] op;
  logic       two_ops;
  logic       one_pop;

  assign two_ops = op == OP_ADD || op == OP_SUB || op == OP_MUL ||
                   op == OP_DIV || op == OP_ST;
  assign one_pop = op == OP_OUT || op == OP_DUP || op == OP_LD ||
                   op == OP_JLT || op == OP_JLE || op == OP_JGT ||
                   op == OP_JGE || op == OP_JEQ || op == OP_JNE;
  assign idle    = state == S_IDLE;

  // Commands per state.
  always_comb begin
    cmd           = '0;
    cmd.load_item = in_fire;
    unique case (state)
      S_POPA: begin
        if (op == OP_DUP) cmd.peek_a = 1'b1;
        else if (two_ops || one_pop) cmd.pop_a = 1'b1;
      end
      S_CAPA: begin
        cmd.cap_a = 1'b1;
        if (two_ops) cmd.pop_b = 1'b1;
      end
      S_CAPB:  cmd.cap_b = 1'b1;
      S_MEM:   cmd.mem_rd = 1'b1;
      S_DIVS:  cmd.div_start = 1'b1;
      S_DONE:  cmd.finish = !out_busy;
      default: ;
    endcase
  end

  // The first pop lands in a, the second in b; a store pops its value first.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          op    <= opcode;
          state <= S_POPA;
        end
        S_POPA:  state <= (two_ops || one_pop) ? S_CAPA : S_DONE;
        S_CAPA:  state <= two_ops ? S_CAPB : (op == OP_LD ? S_MEM : S_DONE);
        S_CAPB:  state <= op == OP_DIV ? S_DIVS : S_DONE;
        S_MEM:   state <= S_MEMW;
        S_MEMW:  state <= S_DONE;
        S_DIVS:  state <= S_DIVW;
        S_DIVW:  if (!sts.div_busy) state <= S_DONE;
        S_DONE:  if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/stack_machine_execute_step_unit.sv
// ============================================================================
// Stack machine execute step unit
// Executes one fetched instruction per item against stack, memory and pc.
// ============================================================================
// One item is taken at a time. A division takes longest, as the divider
// produces one quotient bit per cycle. The result is held in an output
// register until taken; the next item can be accepted while it waits, but
// its result is not committed until the held one is taken.
`default_nettype none

module stack_machine_execute_step_unit
  import sm_exec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: opcode[7:0], immediate[39:8], in_value[71:40]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[2:0], next_pc[13:3], out_valid[14], out_value[46:15],
  // stack_fault[47]
  output logic [47:0]      m_axis_tdata
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        idle;
  logic        in_fire;
  logic [2:0]  status;
  logic [10:0] next_pc;
  logic        out_valid;
  logic [31:0] out_value;
  logic        stack_fault;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {stack_fault, out_value, out_valid, next_pc, status};

  sm_exec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .opcode   (s_axis_tdata[7:0]),
    .out_busy (m_axis_tvalid && !m_axis_tready),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  sm_exec_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (s_axis_tdata[7:0]),
    .immediate   (s_axis_tdata[39:8]),
    .in_value    (s_axis_tdata[71:40]),
    .status      (status),
    .next_pc     (next_pc),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .stack_fault (stack_fault)
  );

  // Output valid follows each committed result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ============================================================================
// Stack machine execute step testbench
// Drives instruction items with random gaps, predicts each step's result from
// a behavioral copy of the machine state, and checks results in order.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
  import sm_exec_pkg::*;

  typedef struct packed {
    logic [31:0] in_value;
    logic [31:0] immediate;
    logic [7:0]  opcode;
  } instr_t;

  typedef struct packed {
    logic        stack_fault;
    logic [31:0] out_value;
    logic        out_valid;
    logic [10:0] next_pc;
    logic [2:0]  status;
  } step_res_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  stack_machine_execute_step_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Predictor state of the machine.
  logic [31:0] mdl_stack [STACK_DEPTH];
  int unsigned mdl_count;
  logic [31:0] mdl_mem [DATA_WORDS];
  int unsigned mdl_pc;
  bit          mdl_stopped;
  logic [2:0]  mdl_stop_code;
  bit          mdl_fault;

  instr_t      pending_items[$];
  step_res_t   expected_results[$];
  int          error_count;
  int          cycle_count;
  int          hold_cycles;
  bit          hold_req;
  bit          pause_send;
  int          send_gap;
  int          recv_gap;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic [31:0] stack_pop();
    if (mdl_count == 0) begin
      mdl_fault = 1;
      return EMPTY_VALUE;
    end
    mdl_count--;
    return mdl_stack[mdl_count];
  endfunction

  function automatic void stack_push(input logic [31:0] v);
    if (mdl_count >= STACK_DEPTH) begin
      mdl_fault = 1;
      return;
    end
    mdl_stack[mdl_count] = v;
    mdl_count++;
  endfunction

  function automatic int unsigned clamp_target(input logic [31:0] t);
    if (t[31] || t >= CODE_WORDS) return CODE_WORDS;
    return t;
  endfunction

  function automatic logic [31:0] signed_quot(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q = mn / md;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  // Executes one instruction on the predictor state.
  function automatic step_res_t execute_instr(input instr_t it);
    step_res_t r;
    logic [31:0] a, b;
    bit take;
    r = '0;
    mdl_fault = 0;
    if (mdl_stopped) begin
      r.status = mdl_stop_code;
    end else if (mdl_pc >= CODE_WORDS) begin
      r.status = ST_CADDR;
    end else begin
      mdl_pc++;
      case (it.opcode)
        OP_HALT: r.status = ST_HALT;
        OP_IN:   stack_push(it.in_value);
        OP_OUT: begin
          r.out_value = stack_pop();
          r.out_valid = 1;
        end
        OP_ADD: begin a = stack_pop(); b = stack_pop(); stack_push(b + a); end
        OP_SUB: begin a = stack_pop(); b = stack_pop(); stack_push(b - a); end
        OP_MUL: begin a = stack_pop(); b = stack_pop(); stack_push(b * a); end
        OP_DIV: begin
          a = stack_pop(); b = stack_pop();
          if (a == 0) r.status = ST_DIV0;
          else stack_push(signed_quot(b, a));
        end
        OP_DUP: begin
          if (mdl_count == 0) begin
            mdl_fault = 1;
            stack_push(EMPTY_VALUE);
          end else stack_push(mdl_stack[mdl_count - 1]);
        end
        OP_LD: begin
          a = stack_pop();
          if (!a[31] && a < DATA_WORDS) stack_push(mdl_mem[a]);
          else r.status = ST_DADDR;
        end
        OP_ST: begin
          b = stack_pop(); a = stack_pop();
          if (!a[31] && a < DATA_WORDS) mdl_mem[a] = b;
          else r.status = ST_DADDR;
        end
        OP_LDC: stack_push(it.immediate);
        OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE: begin
          a = stack_pop();
          case (it.opcode)
            OP_JLT:  take = a[31];
            OP_JLE:  take = a[31] || a == 0;
            OP_JGT:  take = !a[31] && a != 0;
            OP_JGE:  take = !a[31];
            OP_JEQ:  take = a == 0;
            default: take = a != 0;
          endcase
          if (take) mdl_pc = clamp_target(it.immediate);
        end
        OP_JMP: mdl_pc = clamp_target(it.immediate);
        default: r.status = ST_BADOP;
      endcase
    end
    if (!mdl_stopped && r.status != ST_OKAY) begin
      mdl_stopped = 1;
      mdl_stop_code = r.status;
    end
    r.next_pc = mdl_pc[10:0];
    r.stack_fault = mdl_fault;
    return r;
  endfunction

  function automatic instr_t mk(input logic [7:0] op, input logic [31:0] imm,
                                input logic [31:0] inv);
    instr_t it;
    it.opcode = op;
    it.immediate = imm;
    it.in_value = inv;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      3: return -$urandom_range(1, 3);
      4: return $urandom_range(0, DATA_WORDS + 4);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed program step: mostly stack-safe, useful operations.
  function automatic instr_t rand_instr(input int depth, input int seg_len);
    logic [7:0] op;
    logic [31:0] imm;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) op = 8'($urandom_range(18, 255));
    else if (r < 4) op = OP_HALT;
    else if (r < 6) op = OP_DIV;
    else if (depth < 2 && r < 60) op = ($urandom_range(0, 1)) ? OP_IN : OP_LDC;
    else op = 8'($urandom_range(1, 17));
    if (op == OP_DIV && $urandom_range(0, 3) != 0) op = OP_MUL;
    if (op >= OP_JLT && op <= OP_JMP && $urandom_range(0, 19) != 0)
      imm = $urandom_range(0, seg_len + 10);
    else if (op == OP_LDC && $urandom_range(0, 1)) imm = $urandom_range(0, DATA_WORDS - 1);
    else imm = rand_word();
    return mk(op, imm, rand_word());
  endfunction

  // Pending items: directed part, then one random program ended by a bad data
  // address load followed by ignored items. Reset is not repeated, so after the
  // first stop the rest of the random part is ignored; instead, runs are
  // kept alive by avoiding stops except near the end of the run.
  initial begin
    int depth;
    instr_t it;
    // Directed: underflow, extremes, every operation but halt, wrap, division overflow.
    pending_items.push_back(mk(OP_OUT, 0, 0));
    pending_items.push_back(mk(OP_DUP, 0, 0));
    pending_items.push_back(mk(OP_ADD, 0, 0));
    pending_items.push_back(mk(OP_IN, 0, 32'h8000_0000));
    pending_items.push_back(mk(OP_LDC, 32'hffff_ffff, 32'hffff_ffff));
    pending_items.push_back(mk(OP_DIV, 0, 0));
    pending_items.push_back(mk(OP_OUT, 0, 0));
    pending_items.push_back(mk(OP_LDC, 32'h7fff_ffff, 0));
    pending_items.push_back(mk(OP_LDC, 32'h7fff_ffff, 0));
    pending_items.push_back(mk(OP_MUL, 0, 0));
    pending_items.push_back(mk(OP_LDC, 255, 0));
    pending_items.push_back(mk(OP_LDC, 32'h1234_5678, 0));
    pending_items.push_back(mk(OP_ST, 0, 0));
    pending_items.push_back(mk(OP_LDC, 255, 0));
    pending_items.push_back(mk(OP_LD, 0, 0));
    pending_items.push_back(mk(OP_SUB, 0, 0));
    pending_items.push_back(mk(OP_JEQ, 3, 0));
    pending_items.push_back(mk(OP_JNE, 40, 0));
    pending_items.push_back(mk(OP_JLT, 1, 0));
    pending_items.push_back(mk(OP_JLE, 2, 0));
    pending_items.push_back(mk(OP_JGT, 3, 0));
    pending_items.push_back(mk(OP_JGE, 1023, 0));
    pending_items.push_back(mk(OP_JMP, 5, 0));
    // Random program, with the stack and memory exercised deeply; stops
    // are rare so most items execute.
    depth = 0;
    for (int i = 0; i < 1900; i++) begin
      it = rand_instr(depth, 1000);
      if (it.opcode == OP_HALT || it.opcode > OP_JMP ||
          (it.opcode == OP_DIV && $urandom_range(0, 1))) it.opcode = OP_DUP;
      if (it.opcode == OP_LD || it.opcode == OP_ST) begin
        if ($urandom_range(0, 1)) it.opcode = OP_DUP;
      end
      if (it.opcode >= OP_JLT && it.opcode <= OP_JMP) it.immediate = $urandom_range(0, 1023);
      if (i > 600 && i < 900) it.opcode = ($urandom_range(0, 9) == 0) ? OP_DUP : OP_IN;
      pending_items.push_back(it);
      depth = (it.opcode == OP_IN || it.opcode == OP_LDC || it.opcode == OP_DUP) ?
              depth + 1 : (depth > 0 ? depth - 1 : 0);
    end
    // Stopping cases at the end: bad data address, then ignored items.
    pending_items.push_back(mk(OP_LDC, 32'hffff_ffff, 0));
    pending_items.push_back(mk(OP_LD, 0, 0));
    for (int i = 0; i < 40; i++) pending_items.push_back(rand_instr(2, 10));
  end

  // Driver: the item at the head of the queue is the one offered.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      send_gap <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // Hold the offered item.
    end else begin
      if (s_axis_tvalid) begin
        expected_results.push_back(execute_instr(instr_t'(s_axis_tdata)));
        void'(pending_items.pop_front());
      end
      if (send_gap > 0 || pause_send || pending_items.size() == 0) begin
        s_axis_tvalid <= 0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        s_axis_tvalid <= 1;
        s_axis_tdata <= pending_items[0];
        send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
                    $urandom_range(1, 4);
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    step_res_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
      recv_gap <= 0;
      hold_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = step_res_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.next_pc != want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
          if (got.out_valid != want.out_valid)
            report_mismatch("out_valid", got.out_valid, want.out_valid);
          if (got.out_value != want.out_value)
            report_mismatch("out_value", got.out_value, want.out_value);
          if (got.stack_fault != want.stack_fault)
            report_mismatch("stack_fault", got.stack_fault, want.stack_fault);
        end
      end
      if (hold_req && hold_cycles == 0) hold_cycles <= 400;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        if ($urandom_range(0, 9) < 3)
          recv_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) :
                      $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) cycle_count <= rst ? 0 : cycle_count + 1;

  // Run control: pressure phases and end of test.
  initial begin
    error_count = 0;
    hold_req = 0;
    pause_send = 0;
    // The machine comes out of reset with data memory reading as zero and no stop.
    mdl_count = 0;
    mdl_pc = 0;
    mdl_stopped = 0;
    mdl_stop_code = ST_OKAY;
    for (int i = 0; i < DATA_WORDS; i++) mdl_mem[i] = '0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    wait (pending_items.size() < 1500);
    @(posedge clk);
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    wait (pending_items.size() < 1000);
    @(posedge clk);
    pause_send <= 1;
    wait (expected_results.size() == 0 && !s_axis_tvalid);
    repeat (50) @(posedge clk);
    pause_send <= 0;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= 2000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
